// File: rtl/core/ss2w_pkg.sv
// Shared types, constants and the hex to seven-segment encoder for the
// two-wire display refresh block. No dependencies.
`timescale 1ns / 1ps

package ss2w_pkg;

  // Default number of display digits.
  localparam int DIGITS_DEF = 4;

  // Number of digit fields carried by one input word.
  localparam int IN_DIGITS = 4;

  // Command bytes of the three transactions.
  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CTRL = 8'h80;

  // Frame geometry in half-bit periods.
  localparam int START_PERIODS = 2;
  localparam int STOP_PERIODS  = 3;
  localparam int BYTE_PERIODS  = 18;
  localparam int SHORT_TRANS   = START_PERIODS + BYTE_PERIODS + STOP_PERIODS;

  // Offsets inside one byte slot.
  localparam logic [4:0] BOFF_ACK_LO = 5'd16;
  localparam logic [4:0] BOFF_LAST   = 5'd17;
  localparam int         BOFF_W      = 5;

  // Configuration port layout.
  localparam int         CFG_ADDR_W  = 3;
  localparam logic [0:0] REG_BRIGHT  = 1'b0;
  localparam logic [0:0] REG_DISP_ON = 1'b1;

  // One result word.
  typedef struct packed {
    logic clk_line;
    logic dio_line;
    logic busy_res;
    logic ack_error;
    logic frame_done;
  } result_t;

  // Segments A..G in bits 0..6.
  function automatic logic [6:0] seg_encode(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'h0: s = 7'h3F;
      4'h1: s = 7'h06;
      4'h2: s = 7'h5B;
      4'h3: s = 7'h4F;
      4'h4: s = 7'h66;
      4'h5: s = 7'h6D;
      4'h6: s = 7'h7D;
      4'h7: s = 7'h07;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h6F;
      4'hA: s = 7'h77;
      4'hB: s = 7'h7C;
      4'hC: s = 7'h39;
      4'hD: s = 7'h5E;
      4'hE: s = 7'h79;
      default: s = 7'h71;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/seven_segment_two_wire_refresh_top.sv
// Top level of the seven-segment two-wire refresh block: input register,
// frame sequencer, result register and configuration port.
// Depends on ss2w_pkg, ss2w_frame and ss2w_cfg.
`timescale 1ns / 1ps

// Channel   Dir  Port group    Payload
// input     in   in_t*         tuser = func, tdata = digits, dots, dio_in
// result    out  out_t*        tdata = line levels and flags, tlast = frame_done
// config    in   cfg_p*        APB-style, brightness at 0x0, display_on at 0x4
//
// One word is accepted per clock cycle while out_tready keeps draining the
// result register; its result passes the input register, then the result
// register, and is presented on out_t* from the result register.
// The whole per-word update is one pass through the frame sequencer logic.
// Reset is synchronous and active low; there is no clearing pass.
// While the result register holds an untaken word, a further word is still
// taken into the input register; in_tready drops only when both are full.

module seven_segment_two_wire_refresh_top
  import ss2w_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input words.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: digit_0[3:0], digit_1[7:4], digit_2[11:8], digit_3[15:12],
  //        dots_mask[19:16], dio_in[20], zero fill[23:21]
  input  logic [23:0]           in_tdata,
  // tuser: func (0 = half-bit tick, 1 = refresh request)
  input  logic                  in_tuser,
  // Result words.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: clk_line[0], dio_line[1], busy_res[2], ack_error[3], zero fill[7:4]
  output logic [7:0]            out_tdata,
  // tlast: frame_done
  output logic                  out_tlast,
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // Input register stage.
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [20:0] s1_data_r;
  logic        s1_func_r;
  logic        s1_go;
  logic        in_acc;

  // Result register stage.
  logic        out_valid_r;
  logic        out_valid_nxt;
  result_t     out_res_r;
  result_t     frame_res;

  logic [2:0]  brightness;
  logic        display_on;

  // The input stage moves whenever the result register is empty or drained
  // in the same cycle, so a word can enter every cycle.
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata[20:0];
      s1_func_r <= in_tuser;
    end
    if (s1_go) begin
      out_res_r <= frame_res;
    end
  end

  // The sequencer state advances exactly when a word leaves the input stage.
  ss2w_frame #(
    .DIGITS (DIGITS)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_go),
    .func       (s1_func_r),
    .digits     (s1_data_r[4*IN_DIGITS-1:0]),
    .dots_mask  (s1_data_r[4*IN_DIGITS +: IN_DIGITS]),
    .dio_in     (s1_data_r[20]),
    .brightness (brightness),
    .display_on (display_on),
    .res        (frame_res)
  );

  ss2w_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .brightness  (brightness),
    .display_on  (display_on)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.ack_error, out_res_r.busy_res,
                       out_res_r.dio_line, out_res_r.clk_line};
  assign out_tlast  = out_res_r.frame_done;

endmodule

// File: rtl/core/ss2w_cfg.sv
// Configuration registers (brightness and display enable) behind an
// APB-style port. Depends on ss2w_pkg.
`timescale 1ns / 1ps

module ss2w_cfg
  import ss2w_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output logic [2:0]            brightness,
  output logic                  display_on
);

  logic       bright_r;
  logic [2:0] bright_lvl_r;
  logic [2:0] bright_lvl_nxt;
  logic       disp_on_r;
  logic       disp_on_nxt;
  logic       wr_en;
  logic [0:0] reg_idx;

  // Registers sit on 32-bit word boundaries; the index is the word number.
  assign reg_idx    = cfg_paddr[2:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    bright_lvl_nxt = bright_lvl_r;
    disp_on_nxt    = disp_on_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_BRIGHT:  bright_lvl_nxt = cfg_pwdata[2:0];
        REG_DISP_ON: disp_on_nxt    = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_lvl_r <= 3'd3;
      disp_on_r    <= 1'b1;
      bright_r     <= 1'b0;
    end else begin
      bright_lvl_r <= bright_lvl_nxt;
      disp_on_r    <= disp_on_nxt;
      bright_r     <= 1'b0;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BRIGHT:  cfg_prdata = {29'd0, bright_lvl_r};
      REG_DISP_ON: cfg_prdata = {31'd0, disp_on_r};
      default:     cfg_prdata = {31'd0, bright_r};
    endcase
  end

  assign brightness = bright_lvl_r;
  assign display_on = disp_on_r;

endmodule

// File: rtl/core/ss2w_frame.sv
// Frame sequencer: segment byte store, transaction/offset counters, the
// acknowledge error flag and the line level decoder. Depends on ss2w_pkg.
`timescale 1ns / 1ps

module ss2w_frame
  import ss2w_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   func,
  input  logic [4*IN_DIGITS-1:0] digits,
  input  logic [IN_DIGITS-1:0]   dots_mask,
  input  logic                   dio_in,
  input  logic [2:0]             brightness,
  input  logic                   display_on,
  output result_t                res
);

  localparam int LONG_TRANS = START_PERIODS + BYTE_PERIODS * (1 + DIGITS) + STOP_PERIODS;
  localparam int OFF_W      = $clog2(LONG_TRANS);
  localparam int K_W        = $clog2(DIGITS + 1);

  localparam logic [OFF_W-1:0] LEN_SHORT = OFF_W'(SHORT_TRANS);
  localparam logic [OFF_W-1:0] LEN_LONG  = OFF_W'(LONG_TRANS);
  localparam logic [OFF_W-1:0] OFF_START = OFF_W'(START_PERIODS);

  typedef enum logic [1:0] {
    TR_DATA,
    TR_ADDR,
    TR_CTRL
  } trans_t;

  trans_t           trans_r, trans_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [BOFF_W-1:0] boff_r, boff_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic             busy_r, busy_nxt;
  logic             err_r, err_nxt;
  logic [7:0]       seg_r   [DIGITS];
  logic [7:0]       seg_nxt [DIGITS];

  logic [OFF_W-1:0] len_cur, len_new;
  logic             ack_slot;
  logic [7:0]       cur_byte;
  logic             lv_clk, lv_dio;

  assign len_cur = (trans_r == TR_ADDR) ? LEN_LONG : LEN_SHORT;
  // Acknowledge sample slot: clock-low half of the ack bit inside a byte.
  assign ack_slot = busy_r && (off_r >= OFF_START) && (off_r < len_cur - OFF_W'(STOP_PERIODS))
                    && (boff_r == BOFF_ACK_LO);

  always_comb begin
    trans_nxt = trans_r;
    off_nxt   = off_r;
    boff_nxt  = boff_r;
    k_nxt     = k_r;
    busy_nxt  = busy_r;
    err_nxt   = err_r;
    for (int i = 0; i < DIGITS; i++) begin
      seg_nxt[i] = seg_r[i];
    end
    if (step) begin
      if (func) begin
        if (!busy_r) begin
          for (int i = 0; i < DIGITS; i++) begin
            if (i < IN_DIGITS) begin
              seg_nxt[i] = {dots_mask[i], seg_encode(digits[4*i +: 4])};
            end
          end
          err_nxt   = 1'b0;
          busy_nxt  = 1'b1;
          trans_nxt = TR_DATA;
          off_nxt   = '0;
          boff_nxt  = '0;
          k_nxt     = '0;
        end
      end else if (busy_r) begin
        if (ack_slot && dio_in) begin
          err_nxt = 1'b1;
        end
        if (off_r == len_cur - OFF_W'(1)) begin
          off_nxt = '0;
          unique case (trans_r)
            TR_DATA: trans_nxt = TR_ADDR;
            TR_ADDR: trans_nxt = TR_CTRL;
            default: begin
              trans_nxt = TR_DATA;
              busy_nxt  = 1'b0;
            end
          endcase
        end else begin
          off_nxt = off_r + OFF_W'(1);
          if (off_r == OFF_START - OFF_W'(1)) begin
            boff_nxt = '0;
            k_nxt    = '0;
          end else if (boff_r == BOFF_LAST) begin
            boff_nxt = '0;
            k_nxt    = k_r + K_W'(1);
          end else begin
            boff_nxt = boff_r + BOFF_W'(1);
          end
        end
      end
    end
  end

  // Byte sent in the coming period.
  always_comb begin
    cur_byte = CMD_ADDR;
    case (trans_nxt)
      TR_DATA: cur_byte = CMD_DATA;
      TR_CTRL: cur_byte = CMD_CTRL | {4'd0, display_on, brightness};
      default: begin
        for (int i = 0; i < DIGITS; i++) begin
          if (k_nxt == K_W'(i + 1)) begin
            cur_byte = seg_r[i];
          end
        end
      end
    endcase
  end

  // Line levels of the coming period.
  assign len_new = (trans_nxt == TR_ADDR) ? LEN_LONG : LEN_SHORT;

  always_comb begin
    lv_clk = 1'b1;
    lv_dio = 1'b1;
    if (off_nxt == '0) begin
      lv_clk = 1'b1;
      lv_dio = 1'b1;
    end else if (off_nxt == OFF_W'(1)) begin
      lv_clk = 1'b1;
      lv_dio = 1'b0;
    end else if (off_nxt == len_new - OFF_W'(STOP_PERIODS)) begin
      lv_clk = 1'b0;
      lv_dio = 1'b0;
    end else if (off_nxt == len_new - OFF_W'(2)) begin
      lv_clk = 1'b1;
      lv_dio = 1'b0;
    end else if (off_nxt == len_new - OFF_W'(1)) begin
      lv_clk = 1'b1;
      lv_dio = 1'b1;
    end else if (boff_nxt < BOFF_ACK_LO) begin
      lv_clk = boff_nxt[0];
      lv_dio = cur_byte[boff_nxt[3:1]];
    end else if (boff_nxt == BOFF_ACK_LO) begin
      lv_clk = 1'b0;
      lv_dio = 1'b1;
    end else begin
      lv_clk = 1'b1;
      lv_dio = 1'b1;
    end
  end

  always_comb begin
    res.ack_error = err_nxt;
    if (busy_nxt) begin
      res.clk_line   = lv_clk;
      res.dio_line   = lv_dio;
      res.busy_res   = 1'b1;
      res.frame_done = (trans_nxt == TR_CTRL) && (off_nxt == LEN_SHORT - OFF_W'(1));
    end else begin
      res.clk_line   = 1'b1;
      res.dio_line   = 1'b1;
      res.busy_res   = 1'b0;
      res.frame_done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r <= TR_DATA;
      off_r   <= '0;
      boff_r  <= '0;
      k_r     <= '0;
      busy_r  <= 1'b0;
      err_r   <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        seg_r[i] <= 8'hFF;
      end
    end else begin
      trans_r <= trans_nxt;
      off_r   <= off_nxt;
      boff_r  <= boff_nxt;
      k_r     <= k_nxt;
      busy_r  <= busy_nxt;
      err_r   <= err_nxt;
      for (int i = 0; i < DIGITS; i++) begin
        seg_r[i] <= seg_nxt[i];
      end
    end
  end

endmodule

// File: rtl/core/ss2w_checker.sv
// Port-level checks for the two-wire refresh block, bound to the top level.
// Depends only on the top level's port names.
`timescale 1ns / 1ps

module ss2w_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // The last period of a frame is always reported as part of a busy frame.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[2])
    else $error("frame_done without busy");

  // Outside a frame both lines rest released high.
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[0] && out_tdata[1])
    else $error("lines not high while idle");

  // A free output side never holds off the input side.
  a_ready_flow: assert property (@(posedge clk)
    out_tready |-> in_tready)
    else $error("input stalled while output ready");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind seven_segment_two_wire_refresh_top ss2w_checker u_ss2w_checker (.*);
